// ----- rtl/core/sorted_index_blob_lookup_defines.svh -----
// Assertion macros for the sorted index lookup block.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SORTED_INDEX_BLOB_LOOKUP_DEFINES_SVH
`define SORTED_INDEX_BLOB_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SIBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SIBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sibl_pkg.sv -----
// Package for the sorted index lookup block: field widths, codes, entry and
// result types, the controller state type and a status-only result helper. No dependencies.
package sibl_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;

  localparam int POS_W  = 8;
  localparam int KEY_W  = 64;
  localparam int OFS_W  = 32;
  localparam int SEQ_W  = 64;
  localparam int ECNT_W = 9;
  localparam int CNT_W  = 10;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;

  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] CFG_MIN_KEY     = 2'd1;
  localparam logic [1:0] CFG_MAX_KEY     = 2'd2;
  localparam logic [1:0] CFG_INDEX_START = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [OFS_W-1:0] start;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] pos;
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] len;
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] seq;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCMP,
    S_ENT,
    S_NXT,
    S_RESP
  } state_t;

  // A result that carries only a status; every other field is zero.
  function automatic res_t status_only(logic [1:0] st);
    res_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

endpackage

// ----- rtl/core/sorted_index_blob_lookup.sv -----
// Sorted index table lookup: entry writes, binary search by key, read by position.
// A write or rejected item goes straight to the response state; a read by position
// reads the entry, then the next entry's start unless it is the last; a search makes
// up to 9 probes for 256 entries, plus that read on a hit; one item at a time.
// Reset (rst_n low at a clock edge) clears the controller, the output valid and the
// configuration registers; the entry memory holds garbage until written.
`include "sorted_index_blob_lookup_defines.svh"

module sorted_index_blob_lookup
  import sibl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_func,
  input  logic [POS_W-1:0] in_position,
  input  logic [KEY_W-1:0] in_key,
  input  logic [OFS_W-1:0] in_entry_start,
  input  logic [SEQ_W-1:0] in_entry_seq,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [POS_W-1:0] out_found_position,
  output logic [OFS_W-1:0] out_value_start,
  output logic [OFS_W-1:0] out_value_length,
  output logic [KEY_W-1:0] out_found_key,
  output logic [SEQ_W-1:0] out_found_seq,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Configuration registers. Writes are taken in any cycle; the user only
  // writes them while no item is in flight.
  logic [ECNT_W-1:0] entry_count_r;
  logic [KEY_W-1:0]  min_key_r;
  logic [KEY_W-1:0]  max_key_r;
  logic [OFS_W-1:0]  index_start_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      min_key_r     <= '0;
      max_key_r     <= '0;
      index_start_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENTRY_COUNT: entry_count_r <= cfg_data[ECNT_W-1:0];
        CFG_MIN_KEY:     min_key_r     <= cfg_data;
        CFG_MAX_KEY:     max_key_r     <= cfg_data;
        CFG_INDEX_START: index_start_r <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective count: a programmed count above the table size acts as the
  // table size.
  logic [CNT_W-1:0] count;
  assign count = (32'(entry_count_r) > 32'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES)
                                                          : CNT_W'(entry_count_r);

  // Controller and working registers.
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;       // search window, lower bound inclusive
  logic [CNT_W-1:0] hi_r, hi_nxt;       // search window, upper bound exclusive
  logic [CNT_W-1:0] cur_r, cur_nxt;     // position being probed or reported
  logic [KEY_W-1:0] key_r, key_nxt;     // search key of the current item
  entry_t           ent_r, ent_nxt;     // matched entry while its successor is read
  res_t             res_r, res_nxt;     // finished result waiting for the output stage
  res_t             out_res_r, out_res_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Entry memory: one write port, one registered read port.
  entry_t           entry_table [TABLE_ENTRIES];
  entry_t           rd_data_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_table[AW'(in_position)] <= '{key: in_key, start: in_entry_start, seq: in_entry_seq};
    end
    if (rd_en) begin
      rd_data_r <= entry_table[rd_addr];
    end
  end

  // The controller takes one item at a time, so a write to the table never
  // overlaps a lookup read of the same item or of a later one.
  logic item_acc;
  logic out_free;
  assign in_stall = (state_r != S_IDLE);
  assign item_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Decode of a newly accepted item.
  logic in_wr_ok;
  logic in_key_out;
  logic in_search_go;
  logic in_read_go;
  assign in_wr_ok     = (in_func == FUNC_WRITE) && (32'(in_position) < 32'(TABLE_ENTRIES));
  assign in_key_out   = (in_key < min_key_r) || (in_key > max_key_r);
  assign in_search_go = (in_func == FUNC_SEARCH) && !in_key_out && (count != '0);
  assign in_read_go   = (in_func == FUNC_READ) && (CNT_W'(in_position) < count);

  // One probe of the binary search: compare, then narrow the window.
  logic             key_gt;
  logic             key_eq;
  logic [CNT_W-1:0] lo_step;
  logic [CNT_W-1:0] hi_step;
  logic [CNT_W-1:0] mid_step;
  logic             miss_end;
  logic [CNT_W-1:0] cur_inc;
  logic             is_last;
  assign key_gt   = key_r > rd_data_r.key;
  assign key_eq   = key_r == rd_data_r.key;
  assign lo_step  = key_gt ? cur_inc : lo_r;
  assign hi_step  = key_gt ? hi_r : cur_r;
  assign mid_step = lo_step + ((hi_step - CNT_W'(1) - lo_step) >> 1);
  assign miss_end = lo_step >= hi_step;
  assign cur_inc  = cur_r + CNT_W'(1);
  assign is_last  = cur_inc >= count;

  // Final result of an entry report. After a successor read the entry sits
  // in ent_r and the successor's start in rd_data_r; for the last entry the
  // index start closes the value instead.
  entry_t           fin_ent;
  logic [OFS_W-1:0] fin_next;
  res_t             fin_res;
  assign fin_ent  = (state_r == S_NXT) ? ent_r : rd_data_r;
  assign fin_next = (state_r == S_NXT) ? rd_data_r.start : index_start_r;

  always_comb begin
    if (fin_next <= fin_ent.start) begin
      fin_res = status_only(ST_ERROR);
    end else begin
      fin_res.status = ST_OK;
      fin_res.pos    = cur_r[POS_W-1:0];
      fin_res.start  = fin_ent.start;
      fin_res.len    = fin_next - fin_ent.start;
      fin_res.key    = fin_ent.key;
      fin_res.seq    = fin_ent.seq;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (item_acc) begin
          if (in_search_go) begin
            state_nxt = S_SCMP;
          end else if (in_read_go) begin
            state_nxt = S_ENT;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCMP: begin
        if (key_eq) begin
          state_nxt = is_last ? S_RESP : S_NXT;
        end else if (miss_end) begin
          state_nxt = S_RESP;
        end
      end
      S_ENT:  state_nxt = is_last ? S_RESP : S_NXT;
      S_NXT:  state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    key_nxt       = key_r;
    ent_nxt       = ent_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en         = 1'b0;
    rd_addr       = AW'(cur_r);
    wr_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (item_acc) begin
          key_nxt = in_key;
          res_nxt = status_only(ST_ERROR);
          case (in_func)
            FUNC_WRITE: begin
              wr_en = in_wr_ok;
              if (in_wr_ok) begin
                res_nxt = status_only(ST_OK);
              end
            end
            FUNC_SEARCH: begin
              if (in_key_out) begin
                res_nxt = status_only(ST_NOT_FOUND);
              end else if (in_search_go) begin
                // First probe at the middle of the valid entries.
                lo_nxt  = '0;
                hi_nxt  = count;
                cur_nxt = (count - CNT_W'(1)) >> 1;
                rd_en   = 1'b1;
                rd_addr = AW'(cur_nxt);
              end
            end
            FUNC_READ: begin
              if (in_read_go) begin
                cur_nxt = CNT_W'(in_position);
                rd_en   = 1'b1;
                rd_addr = AW'(cur_nxt);
              end
            end
            default: ;
          endcase
        end
      end
      S_SCMP: begin
        if (key_eq) begin
          ent_nxt = rd_data_r;
          if (is_last) begin
            res_nxt = fin_res;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(cur_inc);
          end
        end else begin
          lo_nxt = lo_step;
          hi_nxt = hi_step;
          if (miss_end) begin
            // A key inside min..max that is absent is an inner error.
            res_nxt = status_only(ST_ERROR);
          end else begin
            cur_nxt = mid_step;
            rd_en   = 1'b1;
            rd_addr = AW'(mid_step);
          end
        end
      end
      S_ENT: begin
        ent_nxt = rd_data_r;
        if (is_last) begin
          res_nxt = fin_res;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(cur_inc);
        end
      end
      S_NXT: begin
        res_nxt = fin_res;
      end
      S_RESP: begin
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    cur_r     <= cur_nxt;
    key_r     <= key_nxt;
    ent_r     <= ent_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_found_position = out_res_r.pos;
  assign out_value_start    = out_res_r.start;
  assign out_value_length   = out_res_r.len;
  assign out_found_key      = out_res_r.key;
  assign out_found_seq      = out_res_r.seq;

  // An accepted item holds off the next one until its result is queued.
  `SIBL_ASSERT_NEXT(a_one_item, item_acc, in_stall, "item accepted while another is in flight")
  // Each probe stays inside a non-empty window within the valid entries.
  `SIBL_ASSERT_NOW(a_window, state_r == S_SCMP,
    (lo_r <= cur_r) && (cur_r < hi_r) && (hi_r <= count), "search probe outside its window")
  // A failed lookup never leaks entry data.
  `SIBL_ASSERT_NOW(a_zero_fields, out_valid && (out_status != ST_OK),
    (out_found_position == '0) && (out_value_start == '0) && (out_value_length == '0)
    && (out_found_key == '0) && (out_found_seq == '0), "error result carries entry data")
  // A successful lookup with a nonzero found key reports a positive value length.
  `SIBL_ASSERT_NOW(a_pos_len, out_valid && (out_status == ST_OK) && (out_found_key != '0),
    out_value_length != '0, "lookup result with zero value length")

endmodule
